// ===== hw/rtl/vcd_pkg.sv =====
// package: opcodes, sizes and types for the voxel cube draw engine
package vcd_pkg;
    localparam int Edge = 8;
    localparam int Rows = Edge * Edge;
    localparam int RowAw = $clog2(Rows);

    typedef enum logic [3:0] {
        OP_FILL = 4'd0, OP_SET = 4'd1, OP_GET = 4'd2, OP_PLANE = 4'd3,
        OP_FBOX = 4'd4, OP_WBOX = 4'd5, OP_EBOX = 4'd6, OP_MIRROR = 4'd7,
        OP_SHIFT = 4'd8, OP_MOVE = 4'd9
    } t_op;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR, S_IDLE, S_RUN, S_DONE
    } t_state;

    typedef struct packed {
        logic             wr_en;
        logic [RowAw-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic [RowAw-1:0] rd_addr;
    } t_mem_req;
endpackage

// ===== hw/rtl/voxel_cube_draw_engine.sv =====
// top level: command sequencer for the voxel cube frame buffer
// The frame buffer lives in two 64 x 8 row memories used as a ping-pong pair. After reset the
// engine clears every row of the active copy before it takes the first beat. A command
// that takes effect reads every row of the active copy, one row per cycle with a registered
// read, and writes the updated row into the other copy in the next cycle; after the walk
// the copies swap, so mirror and shift never see a row they have already changed. The result
// is loaded once the walk is over for a command that takes effect and without a walk for one
// that does nothing; the next beat is taken the cycle
// after the result is loaded. The result sits in an output register one beat deep; a result
// still waiting there holds the engine in its done state until it is taken.
module voxel_cube_draw_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_opcode,
    input  logic [3:0] i_x_a,
    input  logic [3:0] i_x_b,
    input  logic [3:0] i_y_a,
    input  logic [3:0] i_y_b,
    input  logic [3:0] i_z_a,
    input  logic [3:0] i_z_b,
    input  logic [7:0] i_fill_pattern,
    input  logic       i_level,
    input  logic [1:0] i_axis,
    input  logic signed [3:0] i_step,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_voxel_bit,
    output logic       o_took_effect
);
    localparam int Aw = vcd_pkg::RowAw;

    vcd_pkg::t_state r_state, n_state;
    logic [Aw:0]   r_cnt, n_cnt;
    logic          r_bank, n_bank;
    logic          r_ov, n_ov, r_obit, r_oeff;
    logic [3:0]    r_op;
    logic [2:0]    r_x1, r_x2, r_y1, r_y2, r_z1, r_z2, r_px, r_py, r_pz;
    logic [2:0]    r_tx, r_ty, r_tz;
    logic [7:0]    r_pat;
    logic          r_level, r_up, r_eff, r_gbit;
    logic [1:0]    r_axis;
    vcd_pkg::t_mem_req req0, req1;
    logic [7:0]    rd0, rd1, rd_data;
    logic          accept, load;

    logic [3:0]    sx1, sx2, sy1, sy2, sz1, sz2, coord, sum;
    logic          inb, eff0;

    logic [Aw-1:0] rd_idx, w_idx, src_addr;
    logic [2:0]    ay, az, wy, wz;
    logic          zero_src, yf, zf, yin, zin;
    logic [7:0]    line, ends, own_bit, tgt_bit, moved, row_new;

    vcd_row_ram u_ram0 (.i_clk(i_clk), .i_req(req0), .o_rd_data(rd0));
    vcd_row_ram u_ram1 (.i_clk(i_clk), .i_req(req1), .o_rd_data(rd1));

    assign rd_data = r_bank ? rd1 : rd0;

    // decode at accept
    always_comb begin
        sx1 = (i_x_a > i_x_b) ? i_x_b : i_x_a;
        sx2 = (i_x_a > i_x_b) ? i_x_a : i_x_b;
        sy1 = (i_y_a > i_y_b) ? i_y_b : i_y_a;
        sy2 = (i_y_a > i_y_b) ? i_y_a : i_y_b;
        sz1 = (i_z_a > i_z_b) ? i_z_b : i_z_a;
        sz2 = (i_z_a > i_z_b) ? i_z_a : i_z_b;
        inb = !i_x_a[3] && !i_y_a[3] && !i_z_a[3];
        coord = (i_axis == vcd_pkg::AXIS_X) ? i_x_a :
                (i_axis == vcd_pkg::AXIS_Y) ? i_y_a : i_z_a;
        sum = coord + $unsigned(i_step);
        eff0 = 1'b0;
        unique case (i_opcode)
            vcd_pkg::OP_FILL: eff0 = 1'b1;
            vcd_pkg::OP_SET, vcd_pkg::OP_GET: eff0 = inb;
            vcd_pkg::OP_PLANE: eff0 = (i_axis != vcd_pkg::AXIS_NONE) && !coord[3];
            vcd_pkg::OP_FBOX, vcd_pkg::OP_WBOX, vcd_pkg::OP_EBOX:
                eff0 = !sx2[3] && !sy2[3] && !sz2[3];
            vcd_pkg::OP_MIRROR: eff0 = (i_axis != vcd_pkg::AXIS_NONE);
            vcd_pkg::OP_SHIFT: eff0 = (i_axis != vcd_pkg::AXIS_NONE) &&
                                      (i_step == 4'sd1 || i_step == -4'sd1);
            vcd_pkg::OP_MOVE: eff0 = (i_axis != vcd_pkg::AXIS_NONE) && inb && !sum[3];
            default: eff0 = 1'b0;
        endcase
    end

    // read side: row issued this cycle, write side: row read in the previous cycle
    assign rd_idx = r_cnt[Aw-1:0];
    assign w_idx = Aw'(r_cnt - 1'b1);
    assign ay = rd_idx[2:0];
    assign az = rd_idx[Aw-1:3];
    assign wy = w_idx[2:0];
    assign wz = w_idx[Aw-1:3];

    always_comb begin
        src_addr = rd_idx;
        if (r_op == vcd_pkg::OP_MIRROR) begin
            if (r_axis == vcd_pkg::AXIS_Y) src_addr = {az, 3'd7 - ay};
            else if (r_axis == vcd_pkg::AXIS_Z) src_addr = {3'd7 - az, ay};
        end else if (r_op == vcd_pkg::OP_SHIFT) begin
            if (r_axis == vcd_pkg::AXIS_Y) src_addr = {az, r_up ? ay - 3'd1 : ay + 3'd1};
            else if (r_axis == vcd_pkg::AXIS_Z) src_addr = {r_up ? az - 3'd1 : az + 3'd1, ay};
        end
    end

    always_comb begin
        zero_src = 1'b0;
        if (r_axis == vcd_pkg::AXIS_Y) zero_src = r_up ? (wy == 3'd0) : (wy == 3'd7);
        else if (r_axis == vcd_pkg::AXIS_Z) zero_src = r_up ? (wz == 3'd0) : (wz == 3'd7);
        line = (8'hFF << r_x1) & ~(8'hFE << r_x2);
        ends = (8'h01 << r_x1) | (8'h01 << r_x2);
        yin = (wy >= r_y1) && (wy <= r_y2);
        zin = (wz >= r_z1) && (wz <= r_z2);
        yf = (wy == r_y1) || (wy == r_y2);
        zf = (wz == r_z1) || (wz == r_z2);
        own_bit = 8'h01 << r_px;
        tgt_bit = 8'h01 << r_tx;
        // move: source cleared first, then target set
        moved = rd_data;
        if (w_idx == {r_pz, r_py}) moved = moved & ~own_bit;
        if (w_idx == {r_tz, r_ty}) moved = moved | tgt_bit;
        row_new = rd_data;
        case (r_op)
            vcd_pkg::OP_FILL: row_new = r_pat;
            vcd_pkg::OP_SET: begin
                if (w_idx == {r_pz, r_py})
                    row_new = r_level ? (rd_data | own_bit) : (rd_data & ~own_bit);
            end
            vcd_pkg::OP_PLANE: begin
                if (r_axis == vcd_pkg::AXIS_X)
                    row_new = r_level ? (rd_data | own_bit) : (rd_data & ~own_bit);
                else if ((r_axis == vcd_pkg::AXIS_Y && wy == r_py) ||
                         (r_axis == vcd_pkg::AXIS_Z && wz == r_pz))
                    row_new = {8{r_level}};
            end
            vcd_pkg::OP_FBOX, vcd_pkg::OP_WBOX, vcd_pkg::OP_EBOX: begin
                if (yin && zin) begin
                    if (r_op == vcd_pkg::OP_FBOX) row_new = rd_data | line;
                    else if (r_op == vcd_pkg::OP_WBOX)
                        row_new = rd_data | ((yf || zf) ? line : ends);
                    else
                        row_new = rd_data | ((yf && zf) ? line : ((yf || zf) ? ends : 8'h00));
                end
            end
            vcd_pkg::OP_MIRROR: begin
                if (r_axis == vcd_pkg::AXIS_X)
                    for (int i = 0; i < 8; i++) row_new[i] = rd_data[7-i];
            end
            vcd_pkg::OP_SHIFT: begin
                if (r_axis == vcd_pkg::AXIS_X)
                    row_new = r_up ? (rd_data >> 1) : (rd_data << 1);
                else if (zero_src)
                    row_new = 8'h00;
            end
            vcd_pkg::OP_MOVE: row_new = moved;
            default: row_new = rd_data;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_bank = r_bank;
        n_ov = r_ov;
        req0 = '0;
        req1 = '0;
        o_ready = 1'b0;
        load = 1'b0;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_state)
            vcd_pkg::S_CLEAR: begin
                req0.wr_en = 1'b1;
                req0.wr_addr = rd_idx;
                req0.wr_data = 8'h00;
                n_cnt = r_cnt + 1'b1;
                if (rd_idx == Aw'(vcd_pkg::Rows - 1)) begin
                    n_cnt = '0;
                    n_state = vcd_pkg::S_IDLE;
                end
            end
            vcd_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cnt = '0;
                    n_state = eff0 ? vcd_pkg::S_RUN : vcd_pkg::S_DONE;
                end
            end
            vcd_pkg::S_RUN: begin
                if (r_bank) begin
                    req1.rd_addr = src_addr;
                    if (r_cnt != '0) begin
                        req0.wr_en = 1'b1;
                        req0.wr_addr = w_idx;
                        req0.wr_data = row_new;
                    end
                end else begin
                    req0.rd_addr = src_addr;
                    if (r_cnt != '0) begin
                        req1.wr_en = 1'b1;
                        req1.wr_addr = w_idx;
                        req1.wr_data = row_new;
                    end
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[Aw]) begin
                    n_cnt = '0;
                    n_bank = !r_bank;
                    n_state = vcd_pkg::S_DONE;
                end
            end
            vcd_pkg::S_DONE: begin
                if (!r_ov || i_ready) begin
                    load = 1'b1;
                    n_ov = 1'b1;
                    n_state = vcd_pkg::S_IDLE;
                end
            end
            default: n_state = vcd_pkg::S_IDLE;
        endcase
    end

    assign accept = o_ready && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vcd_pkg::S_CLEAR;
            r_cnt <= '0;
            r_bank <= 1'b0;
            r_ov <= 1'b0;
            r_obit <= 1'b0;
            r_oeff <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_bank <= n_bank;
            r_ov <= n_ov;
            if (load) begin
                r_obit <= r_gbit;
                r_oeff <= r_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_opcode;
            r_x1 <= sx1[2:0];
            r_x2 <= sx2[2:0];
            r_y1 <= sy1[2:0];
            r_y2 <= sy2[2:0];
            r_z1 <= sz1[2:0];
            r_z2 <= sz2[2:0];
            r_px <= i_x_a[2:0];
            r_py <= i_y_a[2:0];
            r_pz <= i_z_a[2:0];
            r_tx <= (i_axis == vcd_pkg::AXIS_X) ? sum[2:0] : i_x_a[2:0];
            r_ty <= (i_axis == vcd_pkg::AXIS_Y) ? sum[2:0] : i_y_a[2:0];
            r_tz <= (i_axis == vcd_pkg::AXIS_Z) ? sum[2:0] : i_z_a[2:0];
            r_pat <= i_fill_pattern;
            r_level <= i_level;
            r_axis <= i_axis;
            r_up <= (i_step == 4'sd1);
            r_eff <= eff0;
            r_gbit <= 1'b0;
        end else if (r_state == vcd_pkg::S_RUN && r_cnt != '0 && r_op == vcd_pkg::OP_GET &&
                     w_idx == {r_pz, r_py}) begin
            r_gbit <= rd_data[r_px];
        end
    end

    assign o_valid = r_ov;
    assign o_voxel_bit = r_obit;
    assign o_took_effect = r_oeff;
endmodule

// ===== hw/rtl/vcd_row_ram.sv =====
// row memory: 64 x 8, one write and one registered read port
module vcd_row_ram (
    input  logic              i_clk,
    input  vcd_pkg::t_mem_req i_req,
    output logic [7:0]        o_rd_data
);
    logic [7:0] r_mem [vcd_pkg::Rows];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        o_rd_data <= r_mem[i_req.rd_addr];
    end
endmodule

// ===== test/voxel_cube_draw_engine_test.sv =====
// testbench: voxel cube draw engine against a behavioral model of the frame buffer
module voxel_cube_draw_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomBeats = 1950;
    localparam int CycleLimit = 1500000;
    localparam int LongHold = 600;

    typedef struct {
        vcd_pkg::t_op    op;
        logic [3:0]      xa, xb, ya, yb, za, zb;
        logic [7:0]      pat;
        logic            level;
        logic [1:0]      axis;
        logic signed [3:0] step;
        logic            chk;
        logic            bit_exp, eff_exp;
    } t_cmd;

    typedef struct {
        logic voxel;
        logic effect;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [3:0] i_opcode = '0;
    logic [3:0] i_x_a = '0, i_x_b = '0, i_y_a = '0, i_y_b = '0, i_z_a = '0, i_z_b = '0;
    logic [7:0] i_fill_pattern = '0;
    logic i_level = 1'b0;
    logic [1:0] i_axis = '0;
    logic signed [3:0] i_step = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_voxel_bit;
    logic o_took_effect;

    logic [7:0] cube_rows [vcd_pkg::Rows];
    t_res pending_results[$];
    int errors = 0;
    int cycles = 0;
    int beats_in = 0;
    int beats_out = 0;
    int op_hits [16];
    bit hold_long = 1'b0;
    bit long_done = 1'b0;

    voxel_cube_draw_engine u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_x_a(i_x_a), .i_x_b(i_x_b), .i_y_a(i_y_a),
        .i_y_b(i_y_b), .i_z_a(i_z_a), .i_z_b(i_z_b), .i_fill_pattern(i_fill_pattern),
        .i_level(i_level), .i_axis(i_axis), .i_step(i_step), .o_valid(o_valid),
        .i_ready(i_ready), .o_voxel_bit(o_voxel_bit), .o_took_effect(o_took_effect)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("%0t timeout after %0d cycles", $realtime, cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int row_at(int y, int z);
        return z * vcd_pkg::Edge + y;
    endfunction

    function automatic void put_voxel(int x, int y, int z, logic on);
        cube_rows[row_at(y, z)][x] = on;
    endfunction

    function automatic t_res apply_cmd(t_cmd c);
        t_res r;
        logic [7:0] prev [vcd_pkg::Rows];
        logic [3:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
        logic [7:0] span, ends, m;
        logic inb, zf, yf;
        int sel, tgt, src;
        r.voxel = 1'b0;
        r.effect = 1'b0;
        inb = c.xa < vcd_pkg::Edge && c.ya < vcd_pkg::Edge && c.za < vcd_pkg::Edge;
        sel = int'(c.axis == vcd_pkg::AXIS_X ? c.xa : c.axis == vcd_pkg::AXIS_Y ? c.ya : c.za);
        prev = cube_rows;
        case (c.op)
            vcd_pkg::OP_FILL: begin
                foreach (cube_rows[i]) cube_rows[i] = c.pat;
                r.effect = 1'b1;
            end
            vcd_pkg::OP_SET: if (inb) begin
                put_voxel(c.xa, c.ya, c.za, c.level);
                r.effect = 1'b1;
            end
            vcd_pkg::OP_GET: if (inb) begin
                r.voxel = cube_rows[row_at(c.ya, c.za)][c.xa];
                r.effect = 1'b1;
            end
            vcd_pkg::OP_PLANE: if (c.axis != vcd_pkg::AXIS_NONE && sel < vcd_pkg::Edge) begin
                for (int i = 0; i < vcd_pkg::Rows; i++) begin
                    if (c.axis == vcd_pkg::AXIS_X) cube_rows[i][sel] = c.level;
                    else if ((c.axis == vcd_pkg::AXIS_Y && i % 8 == sel) ||
                             (c.axis == vcd_pkg::AXIS_Z && i / 8 == sel))
                        cube_rows[i] = {8{c.level}};
                end
                r.effect = 1'b1;
            end
            vcd_pkg::OP_FBOX, vcd_pkg::OP_WBOX, vcd_pkg::OP_EBOX: begin
                lo_x = c.xa < c.xb ? c.xa : c.xb;
                hi_x = c.xa < c.xb ? c.xb : c.xa;
                lo_y = c.ya < c.yb ? c.ya : c.yb;
                hi_y = c.ya < c.yb ? c.yb : c.ya;
                lo_z = c.za < c.zb ? c.za : c.zb;
                hi_z = c.za < c.zb ? c.zb : c.za;
                if (hi_x < vcd_pkg::Edge && hi_y < vcd_pkg::Edge && hi_z < vcd_pkg::Edge) begin
                    span = '0;
                    for (int x = lo_x; x <= hi_x; x++) span[x] = 1'b1;
                    ends = '0;
                    ends[lo_x] = 1'b1;
                    ends[hi_x] = 1'b1;
                    for (int z = lo_z; z <= hi_z; z++) begin
                        for (int y = lo_y; y <= hi_y; y++) begin
                            zf = z == lo_z || z == hi_z;
                            yf = y == lo_y || y == hi_y;
                            if (c.op == vcd_pkg::OP_FBOX) m = span;
                            else if (c.op == vcd_pkg::OP_WBOX) m = (zf || yf) ? span : ends;
                            else m = (zf && yf) ? span : ((zf || yf) ? ends : 8'h00);
                            cube_rows[row_at(y, z)] |= m;
                        end
                    end
                    r.effect = 1'b1;
                end
            end
            vcd_pkg::OP_MIRROR: if (c.axis != vcd_pkg::AXIS_NONE) begin
                for (int z = 0; z < vcd_pkg::Edge; z++) begin
                    for (int y = 0; y < vcd_pkg::Edge; y++) begin
                        if (c.axis == vcd_pkg::AXIS_X) begin
                            for (int b = 0; b < 8; b++)
                                cube_rows[row_at(y, z)][b] = prev[row_at(y, z)][7 - b];
                        end else if (c.axis == vcd_pkg::AXIS_Y) begin
                            cube_rows[row_at(y, z)] = prev[row_at(7 - y, z)];
                        end else begin
                            cube_rows[row_at(y, z)] = prev[row_at(y, 7 - z)];
                        end
                    end
                end
                r.effect = 1'b1;
            end
            vcd_pkg::OP_SHIFT:
            if (c.axis != vcd_pkg::AXIS_NONE && (c.step == 1 || c.step == -1)) begin
                for (int z = 0; z < vcd_pkg::Edge; z++) begin
                    for (int y = 0; y < vcd_pkg::Edge; y++) begin
                        if (c.axis == vcd_pkg::AXIS_X) begin
                            cube_rows[row_at(y, z)] = c.step == 1 ? prev[row_at(y, z)] >> 1
                                                                 : prev[row_at(y, z)] << 1;
                        end else begin
                            src = (c.axis == vcd_pkg::AXIS_Y ? y : z) - c.step;
                            if (src < 0 || src > 7)
                                cube_rows[row_at(y, z)] = 8'h00;
                            else if (c.axis == vcd_pkg::AXIS_Y)
                                cube_rows[row_at(y, z)] = prev[row_at(src, z)];
                            else
                                cube_rows[row_at(y, z)] = prev[row_at(y, src)];
                        end
                    end
                end
                r.effect = 1'b1;
            end
            vcd_pkg::OP_MOVE: if (c.axis != vcd_pkg::AXIS_NONE && inb) begin
                tgt = sel + c.step;
                if (tgt >= 0 && tgt < vcd_pkg::Edge) begin
                    put_voxel(c.xa, c.ya, c.za, 1'b0);
                    if (c.axis == vcd_pkg::AXIS_X) put_voxel(tgt, c.ya, c.za, 1'b1);
                    else if (c.axis == vcd_pkg::AXIS_Y) put_voxel(c.xa, tgt, c.za, 1'b1);
                    else put_voxel(c.xa, c.ya, tgt, 1'b1);
                    r.effect = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_cmd(t_cmd c);
        t_res r;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        r = apply_cmd(c);
        if (c.chk && (r.voxel !== c.bit_exp || r.effect !== c.eff_exp)) begin
            $display("%0t table row mismatch op %0d: expected %b/%b actual %b/%b",
                     $realtime, c.op, c.bit_exp, c.eff_exp, r.voxel, r.effect);
            errors++;
        end
        pending_results.push_back(r);
        op_hits[c.op]++;
        i_valid <= 1'b1;
        i_opcode <= c.op;
        i_x_a <= c.xa; i_x_b <= c.xb;
        i_y_a <= c.ya; i_y_b <= c.yb;
        i_z_a <= c.za; i_z_b <= c.zb;
        i_fill_pattern <= c.pat;
        i_level <= c.level;
        i_axis <= c.axis;
        i_step <= c.step;
        do @(posedge i_clk); while (!o_ready);
        beats_in++;
    endtask

    function automatic t_cmd mk(int op, int xa = 0, int ya = 0, int za = 0, int xb = 0,
                                int yb = 0, int zb = 0, int pat = 0, int level = 0,
                                int axis = 0, int step = 0, int chk = 0, int bexp = 0,
                                int eexp = 0);
        t_cmd c;
        c.op = vcd_pkg::t_op'(op);
        c.xa = 4'(xa); c.ya = 4'(ya); c.za = 4'(za);
        c.xb = 4'(xb); c.yb = 4'(yb); c.zb = 4'(zb);
        c.pat = 8'(pat); c.level = 1'(level); c.axis = 2'(axis); c.step = 4'(step);
        c.chk = 1'(chk); c.bit_exp = 1'(bexp); c.eff_exp = 1'(eexp);
        return c;
    endfunction

    function automatic logic [3:0] coord_pick();
        return $urandom_range(0, 9) == 0 ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int sel;
        sel = $urandom_range(0, 99);
        c.op = sel < 3 ? vcd_pkg::OP_FILL : sel < 20 ? vcd_pkg::OP_SET :
               sel < 40 ? vcd_pkg::OP_GET : sel < 47 ? vcd_pkg::OP_PLANE :
               sel < 52 ? vcd_pkg::OP_FBOX : sel < 57 ? vcd_pkg::OP_WBOX :
               sel < 62 ? vcd_pkg::OP_EBOX : sel < 67 ? vcd_pkg::OP_MIRROR :
               sel < 74 ? vcd_pkg::OP_SHIFT : sel < 96 ? vcd_pkg::OP_MOVE :
               vcd_pkg::t_op'($urandom_range(10, 15));
        c.xa = coord_pick(); c.ya = coord_pick(); c.za = coord_pick();
        c.xb = coord_pick(); c.yb = coord_pick(); c.zb = coord_pick();
        if ($urandom_range(0, 49) == 0) begin
            c.xa = 4'($urandom); c.xb = 4'($urandom); c.ya = 4'($urandom);
        end
        c.pat = 8'($urandom);
        c.level = $urandom_range(0, 3) != 0;
        c.axis = $urandom_range(0, 15) == 0 ? vcd_pkg::AXIS_NONE : 2'($urandom_range(0, 2));
        if (c.op == vcd_pkg::OP_SHIFT && $urandom_range(0, 7) != 0)
            c.step = $urandom_range(0, 1) ? 4'sd1 : -4'sd1;
        else
            c.step = 4'($urandom);
        c.chk = 1'b0;
        c.bit_exp = 1'b0;
        c.eff_exp = 1'b0;
        return c;
    endfunction

    // receiver with random stalls and one long hold
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_long && !long_done) begin
                i_ready <= 1'b0;
                repeat (LongHold) @(posedge i_clk);
                long_done = 1'b1;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && i_ready) begin
            beats_out++;
            if (pending_results.size() == 0) begin
                $display("%0t result beat with nothing expected: actual %b/%b",
                         $realtime, o_voxel_bit, o_took_effect);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_voxel_bit !== e.voxel) begin
                    $display("%0t voxel_bit mismatch: expected %b actual %b",
                             $realtime, e.voxel, o_voxel_bit);
                    errors++;
                end
                if (o_took_effect !== e.effect) begin
                    $display("%0t took_effect mismatch: expected %b actual %b",
                             $realtime, e.effect, o_took_effect);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_cmd table_rows[$];
        foreach (cube_rows[i]) cube_rows[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        table_rows = {
            mk(vcd_pkg::OP_GET, 7, 7, 7, .chk(1), .bexp(0), .eexp(1)),
            mk(vcd_pkg::OP_GET, 8, 0, 0, .chk(1), .bexp(0), .eexp(0)),
            mk(vcd_pkg::OP_SET, 15, 15, 15, .level(1), .chk(1), .bexp(0), .eexp(0)),
            mk(vcd_pkg::OP_FILL, .pat(8'hFF), .chk(1), .bexp(0), .eexp(1)),
            mk(vcd_pkg::OP_GET, 0, 0, 0, .chk(1), .bexp(1), .eexp(1)),
            mk(vcd_pkg::OP_SET, 0, 0, 0, .level(0)),
            mk(vcd_pkg::OP_GET, 0, 0, 0, .chk(1), .bexp(0), .eexp(1)),
            mk(vcd_pkg::OP_FILL, .pat(8'h00)),
            mk(vcd_pkg::OP_PLANE, 3, 0, 0, .level(1), .axis(vcd_pkg::AXIS_X)),
            mk(vcd_pkg::OP_PLANE, 0, 7, 0, .level(1), .axis(vcd_pkg::AXIS_Y)),
            mk(vcd_pkg::OP_PLANE, 0, 0, 9, .axis(vcd_pkg::AXIS_Z), .chk(1), .bexp(0), .eexp(0)),
            mk(vcd_pkg::OP_PLANE, 0, 0, 2, .axis(vcd_pkg::AXIS_NONE), .chk(1), .bexp(0),
               .eexp(0)),
            mk(vcd_pkg::OP_FBOX, 6, 5, 4, 1, 2, 3),
            mk(vcd_pkg::OP_WBOX, 0, 0, 0, 7, 7, 7),
            mk(vcd_pkg::OP_EBOX, 7, 7, 7, 0, 0, 0),
            mk(vcd_pkg::OP_EBOX, 1, 1, 1, 8, 1, 1, .chk(1), .bexp(0), .eexp(0)),
            mk(vcd_pkg::OP_MIRROR, .axis(vcd_pkg::AXIS_X)),
            mk(vcd_pkg::OP_MIRROR, .axis(vcd_pkg::AXIS_Y)),
            mk(vcd_pkg::OP_MIRROR, .axis(vcd_pkg::AXIS_Z)),
            mk(vcd_pkg::OP_SHIFT, .axis(vcd_pkg::AXIS_X), .step(-1)),
            mk(vcd_pkg::OP_SHIFT, .axis(vcd_pkg::AXIS_Y), .step(1)),
            mk(vcd_pkg::OP_SHIFT, .axis(vcd_pkg::AXIS_Z), .step(2), .chk(1), .bexp(0),
               .eexp(0)),
            mk(vcd_pkg::OP_MOVE, 2, 3, 4, .axis(vcd_pkg::AXIS_Z), .step(0)),
            mk(vcd_pkg::OP_MOVE, 0, 0, 0, .axis(vcd_pkg::AXIS_X), .step(-7), .chk(1),
               .bexp(0), .eexp(0)),
            mk(15, 15, 15, 15, 15, 15, 15, 8'hFF, 1, vcd_pkg::AXIS_NONE, -8, .chk(1),
               .bexp(0), .eexp(0))
        };
        foreach (table_rows[i]) send_cmd(table_rows[i]);

        for (int n = 0; n < RandomBeats; n++) begin
            if (n == RandomBeats / 3) hold_long = 1'b1;
            if (n == RandomBeats / 2 || n == (3 * RandomBeats) / 4) begin
                i_valid <= 1'b0;
                wait (pending_results.size() == 0);
            end
            send_cmd(rand_cmd());
        end

        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("%0d command beats sent, %0d result beats checked, %0d cycles",
                 beats_in, beats_out, cycles);
        $display("beats per opcode 0..9: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4],
                 op_hits[5], op_hits[6], op_hits[7], op_hits[8], op_hits[9]);
        if (errors == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
